// ===== rtl/core/gregorian_to_jalali_date_macros.svh =====
// Assertion macros shared by the date converter RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef GREGORIAN_TO_JALALI_DATE_MACROS_SVH
`define GREGORIAN_TO_JALALI_DATE_MACROS_SVH

// same-cycle implication, checked out of reset
`define G2J_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("g2j assertion failed");

// next-cycle implication, checked out of reset
`define G2J_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("g2j assertion failed");

`endif

// ===== rtl/core/g2j_pkg.sv =====
// Constants and month tables for the Gregorian to Jalali date converter.
// No dependencies.
package g2j_pkg;

    localparam int NUM_STAGES = 10;

    localparam int EPOCH_DAYS     = 355666;
    localparam int DAYS_PER_YEAR  = 365;
    localparam int DAYS_33Y       = 12053;
    localparam int DAYS_4Y        = 1461;
    localparam int YEARS_33       = 33;
    // -1595 modulo 2^11
    localparam int YEAR_BIAS      = 453;

    // reciprocal multipliers: x/25 = (x*2622)>>16, estimates for the cycle splits
    localparam int RECIP_25       = 2622;
    localparam int RECIP_25_SHIFT = 16;
    localparam int RECIP_33Y      = 173;
    localparam int RECIP_33Y_SHIFT = 21;
    localparam int RECIP_4Y       = 11;
    localparam int RECIP_4Y_SHIFT = 14;

    // days in the Gregorian months before month index+1
    function automatic logic [8:0] greg_cum(input logic [3:0] months_before);
        logic [8:0] d;
        case (months_before)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

    // first day of year (zero based) of Jalali month index
    function automatic logic [8:0] sol_start(input logic [3:0] month_idx);
        logic [8:0] d;
        case (month_idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd62;
            4'd3:    d = 9'd93;
            4'd4:    d = 9'd124;
            4'd5:    d = 9'd155;
            4'd6:    d = 9'd186;
            4'd7:    d = 9'd216;
            4'd8:    d = 9'd246;
            4'd9:    d = 9'd276;
            4'd10:   d = 9'd306;
            default: d = 9'd336;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/gregorian_to_jalali_date.sv =====
// Gregorian to Jalali date converter, ten-stage pipeline.
// Depends on g2j_pkg and gregorian_to_jalali_date_macros.svh.
//
// One Gregorian date word in, one Jalali date word out, in order. The
// pipeline takes a new word every cycle while the result side keeps up; each
// stage holds its word when the stage after it is full and stalled, so empty
// stages still fill while a finished result waits. Stages: day count parts,
// day count sum, 33-year quotient estimate, remainder, correction, 4-year
// quotient estimate, remainder, correction, 365-day split, month lookup.
module gregorian_to_jalali_date
    import g2j_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_greg_year,
    input  logic [3:0]  s_greg_month,
    input  logic [4:0]  s_greg_day,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_solar_year,
    output logic [3:0]  m_solar_month,
    output logic [4:0]  m_solar_day
);

`include "gregorian_to_jalali_date_macros.svh"

    logic [NUM_STAGES-1:0] valid_reg, valid_next, stage_en;

    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    // stage 1: day count parts
    logic [12:0] leap_year;
    logic [3:0]  months_before;
    logic [10:0] x100;
    logic [8:0]  x400;
    logic [20:0] s1_gy365_reg, s1_gy365_next;
    logic [10:0] s1_ly4_reg, s1_ly4_next;
    logic [22:0] s1_p100_reg, s1_p100_next;
    logic [20:0] s1_p400_reg, s1_p400_next;
    logic [18:0] s1_base_reg, s1_base_next;

    always_comb begin
        leap_year = (s_greg_month > 4'd2) ? ({1'b0, s_greg_year} + 13'd1)
                                          : {1'b0, s_greg_year};
        if (s_greg_month == 4'd0) begin
            months_before = 4'd0;
        end else if (s_greg_month > 4'd12) begin
            months_before = 4'd12;
        end else begin
            months_before = s_greg_month - 4'd1;
        end
        x100          = 11'((leap_year + 13'd99) >> 2);
        x400          = 9'((leap_year + 13'd399) >> 4);
        s1_gy365_next = {9'd0, s_greg_year} * 21'(DAYS_PER_YEAR);
        s1_ly4_next   = 11'((leap_year + 13'd3) >> 2);
        s1_p100_next  = {12'd0, x100} * 23'(RECIP_25);
        s1_p400_next  = {12'd0, x400} * 21'(RECIP_25);
        s1_base_next  = 19'(EPOCH_DAYS) + {14'd0, s_greg_day}
                      + {10'd0, greg_cum(months_before)};
    end

    // stage 2: day count
    logic [20:0] s2_days_reg, s2_days_next;

    assign s2_days_next = s1_gy365_reg + {2'd0, s1_base_reg} + {10'd0, s1_ly4_reg}
                        + {16'd0, s1_p400_reg[20:RECIP_25_SHIFT]}
                        - {14'd0, s1_p100_reg[22:RECIP_25_SHIFT]};

    // stage 3: 33-year quotient estimate
    logic [28:0] prod33;
    logic [20:0] s3_days_reg;
    logic [7:0]  s3_q_reg, s3_q_next;

    assign prod33    = {8'd0, s2_days_reg} * 29'(RECIP_33Y);
    assign s3_q_next = prod33[28:RECIP_33Y_SHIFT];

    // stage 4: 33-year remainder
    logic [20:0] sub33;
    logic [7:0]  s4_q_reg;
    logic [14:0] s4_r_reg, s4_r_next;

    assign sub33     = {13'd0, s3_q_reg} * 21'(DAYS_33Y);
    assign s4_r_next = 15'(s3_days_reg - sub33);

    // stage 5: correct the estimate, 33-year part of the year
    logic        ge33;
    logic [7:0]  q33_fix;
    logic [10:0] s5_year_reg, s5_year_next;
    logic [13:0] s5_r_reg, s5_r_next;

    always_comb begin
        ge33         = s4_r_reg >= 15'(DAYS_33Y);
        q33_fix      = ge33 ? s4_q_reg + 8'd1 : s4_q_reg;
        s5_r_next    = ge33 ? 14'(s4_r_reg - 15'(DAYS_33Y)) : s4_r_reg[13:0];
        s5_year_next = {3'd0, q33_fix} * 11'(YEARS_33);
    end

    // stage 6: 4-year quotient estimate
    logic [17:0] prod4;
    logic [10:0] s6_year_reg;
    logic [13:0] s6_r_reg;
    logic [3:0]  s6_q_reg, s6_q_next;

    assign prod4     = {4'd0, s5_r_reg} * 18'(RECIP_4Y);
    assign s6_q_next = prod4[17:RECIP_4Y_SHIFT];

    // stage 7: 4-year remainder
    logic [13:0] sub4;
    logic [10:0] s7_year_reg;
    logic [3:0]  s7_q_reg;
    logic [11:0] s7_r_reg, s7_r_next;

    assign sub4      = {10'd0, s6_q_reg} * 14'(DAYS_4Y);
    assign s7_r_next = 12'(s6_r_reg - sub4);

    // stage 8: correct the estimate, 4-year part of the year
    logic        ge4;
    logic [3:0]  q4_fix;
    logic [10:0] s8_year_reg, s8_year_next;
    logic [10:0] s8_r_reg, s8_r_next;

    always_comb begin
        ge4          = s7_r_reg >= 12'(DAYS_4Y);
        q4_fix       = ge4 ? s7_q_reg + 4'd1 : s7_q_reg;
        s8_r_next    = ge4 ? 11'(s7_r_reg - 12'(DAYS_4Y)) : s7_r_reg[10:0];
        s8_year_next = s7_year_reg + {5'd0, q4_fix, 2'b00};
    end

    // stage 9: split off whole 365-day years, apply year offset
    logic [10:0] past_leap;
    logic [1:0]  q1;
    logic [10:0] sub1;
    logic [10:0] s9_year_reg, s9_year_next;
    logic [8:0]  s9_doy_reg, s9_doy_next;

    always_comb begin
        past_leap = s8_r_reg - 11'd1;
        if (s8_r_reg <= 11'(DAYS_PER_YEAR)) begin
            q1   = 2'd0;
            sub1 = 11'd0;
        end else if (past_leap >= 11'(3 * DAYS_PER_YEAR)) begin
            q1   = 2'd3;
            sub1 = 11'(3 * DAYS_PER_YEAR + 1);
        end else if (past_leap >= 11'(2 * DAYS_PER_YEAR)) begin
            q1   = 2'd2;
            sub1 = 11'(2 * DAYS_PER_YEAR + 1);
        end else begin
            q1   = 2'd1;
            sub1 = 11'(DAYS_PER_YEAR + 1);
        end
        s9_doy_next  = 9'(s8_r_reg - sub1);
        s9_year_next = s8_year_reg + {9'd0, q1} + 11'(YEAR_BIAS);
    end

    // stage 10: month and day
    logic [3:0]  month_idx;
    logic [8:0]  day_ofs;
    logic [10:0] s10_year_reg;
    logic [3:0]  s10_month_reg, s10_month_next;
    logic [4:0]  s10_day_reg, s10_day_next;

    always_comb begin
        month_idx = 4'd0;
        for (int k = 1; k < 12; k++) begin
            month_idx = month_idx + {3'd0, (s9_doy_reg >= sol_start(4'(k)))};
        end
        day_ofs        = s9_doy_reg - sol_start(month_idx);
        s10_month_next = month_idx + 4'd1;
        s10_day_next   = 5'(day_ofs + 9'd1);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s1_gy365_reg <= s1_gy365_next;
            s1_ly4_reg   <= s1_ly4_next;
            s1_p100_reg  <= s1_p100_next;
            s1_p400_reg  <= s1_p400_next;
            s1_base_reg  <= s1_base_next;
        end
        if (stage_en[1]) begin
            s2_days_reg <= s2_days_next;
        end
        if (stage_en[2]) begin
            s3_days_reg <= s2_days_reg;
            s3_q_reg    <= s3_q_next;
        end
        if (stage_en[3]) begin
            s4_q_reg <= s3_q_reg;
            s4_r_reg <= s4_r_next;
        end
        if (stage_en[4]) begin
            s5_year_reg <= s5_year_next;
            s5_r_reg    <= s5_r_next;
        end
        if (stage_en[5]) begin
            s6_year_reg <= s5_year_reg;
            s6_r_reg    <= s5_r_reg;
            s6_q_reg    <= s6_q_next;
        end
        if (stage_en[6]) begin
            s7_year_reg <= s6_year_reg;
            s7_q_reg    <= s6_q_reg;
            s7_r_reg    <= s7_r_next;
        end
        if (stage_en[7]) begin
            s8_year_reg <= s8_year_next;
            s8_r_reg    <= s8_r_next;
        end
        if (stage_en[8]) begin
            s9_year_reg <= s9_year_next;
            s9_doy_reg  <= s9_doy_next;
        end
        if (stage_en[9]) begin
            s10_year_reg  <= s9_year_reg;
            s10_month_reg <= s10_month_next;
            s10_day_reg   <= s10_day_next;
        end
    end

    assign m_solar_year  = s10_year_reg;
    assign m_solar_month = s10_month_reg;
    assign m_solar_day   = s10_day_reg;

    `G2J_ASSERT_IMPL(a_full_stall_blocks_input, aclk, aresetn,
                     (&valid_reg) && !m_ready, !s_ready)
    `G2J_ASSERT_IMPL(a_rem33_in_range, aclk, aresetn,
                     valid_reg[4], s5_r_reg < 14'(DAYS_33Y))
    `G2J_ASSERT_IMPL(a_rem4_in_range, aclk, aresetn,
                     valid_reg[7], s8_r_reg < 11'(DAYS_4Y))
    `G2J_ASSERT_IMPL(a_doy_in_range, aclk, aresetn,
                     valid_reg[8], s9_doy_reg <= 9'(DAYS_PER_YEAR))
    `G2J_ASSERT_IMPL(a_month_day_legal, aclk, aresetn,
                     m_valid, (m_solar_month != 4'd0) && (m_solar_month <= 4'd12)
                     && (m_solar_day != 5'd0))

endmodule

// ===== tb/gregorian_to_jalali_date_tb.sv =====
// Testbench for gregorian_to_jalali_date: Gregorian dates in, Jalali dates checked out.
// Depends only on the gregorian_to_jalali_date RTL; it predicts each result itself and
// checks the results in order with random gaps on both handshakes.
module gregorian_to_jalali_date_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } solar_date_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [11:0] s_greg_year = '0;
    logic [3:0]  s_greg_month = '0;
    logic [4:0]  s_greg_day = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [10:0] m_solar_year;
    logic [3:0]  m_solar_month;
    logic [4:0]  m_solar_day;

    solar_date_t solar_expect[$];
    int unsigned greg_month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int unsigned solar_month_days[12] = '{31, 31, 31, 31, 31, 31, 30, 30, 30, 30, 30, 29};
    int mismatches = 0;
    int stall_cycles = 0;
    bit src_idle = 1'b0;
    bit sink_idle = 1'b0;

    gregorian_to_jalali_date DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_greg_year   (s_greg_year),
        .s_greg_month  (s_greg_month),
        .s_greg_day    (s_greg_day),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_solar_year  (m_solar_year),
        .m_solar_month (m_solar_month),
        .m_solar_day   (m_solar_day)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic solar_date_t gregorian_to_solar(input logic [11:0] gy_in,
                                                       input logic [3:0] gm_in,
                                                       input logic [4:0] gd_in);
        int unsigned gy, gm, gd, leap_year, months_before, days, yr, mi;
        solar_date_t result;
        gy = gy_in;
        gm = gm_in;
        gd = gd_in;
        leap_year = (gm > 2) ? gy + 1 : gy;
        months_before = (gm == 0) ? 0 : ((gm > 12) ? 12 : gm - 1);
        days = 32'd355666 + 32'd365 * gy + (leap_year + 32'd3) / 32'd4
             - (leap_year + 32'd99) / 32'd100 + (leap_year + 32'd399) / 32'd400 + gd;
        for (int k = 0; k < months_before; k++)
            days += greg_month_days[k];
        yr = 32'd33 * (days / 32'd12053);
        days = days % 32'd12053;
        yr += 32'd4 * (days / 32'd1461);
        days = days % 32'd1461;
        if (days > 32'd365) begin
            yr += (days - 32'd1) / 32'd365;
            days = (days - 32'd1) % 32'd365;
        end
        yr -= 32'd1595;
        mi = 0;
        while (mi < 11 && days >= solar_month_days[mi]) begin
            days -= solar_month_days[mi];
            mi++;
        end
        mi = mi + 1;
        days = days + 1;
        result.year = yr[10:0];
        result.month = mi[3:0];
        result.day = days[4:0];
        return result;
    endfunction

    always @(posedge aclk) begin
        solar_date_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (solar_expect.size() == 0) begin
                    $error("result word with nothing expected: %0d-%0d-%0d",
                           m_solar_year, m_solar_month, m_solar_day);
                    mismatches++;
                end else begin
                    want = solar_expect.pop_front();
                    if (m_solar_year !== want.year) begin
                        $error("solar_year: expected %0d, actual %0d", want.year, m_solar_year);
                        mismatches++;
                    end
                    if (m_solar_month !== want.month) begin
                        $error("solar_month: expected %0d, actual %0d",
                               want.month, m_solar_month);
                        mismatches++;
                    end
                    if (m_solar_day !== want.day) begin
                        $error("solar_day: expected %0d, actual %0d", want.day, m_solar_day);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                solar_expect.push_back(gregorian_to_solar(s_greg_year, s_greg_month,
                                                          s_greg_day));
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles == STALL_LIMIT) begin
                $display("gregorian_to_jalali_date_tb failed");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = sink_idle ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    task automatic send_date(input int y, input int m, input int d);
        int gap;
        gap = src_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_greg_year <= y[11:0];
        s_greg_month <= m[3:0];
        s_greg_day <= d[4:0];
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (solar_expect.size() != 0) @(negedge aclk);
    endtask

    task automatic test_range_edges();
        send_date(1900, 1, 1);
        send_date(2100, 12, 31);
        send_date(0, 1, 1);
        send_date(4095, 12, 31);
    endtask

    task automatic test_leap_days();
        send_date(2000, 2, 29);
        send_date(2000, 3, 1);
        send_date(1900, 2, 28);
        send_date(1900, 3, 1);
        send_date(2024, 2, 29);
        send_date(2100, 2, 28);
        send_date(2100, 3, 1);
    endtask

    task automatic test_new_year();
        send_date(2023, 3, 20);
        send_date(2023, 3, 21);
        send_date(2024, 3, 20);
        send_date(2025, 3, 21);
        send_date(2024, 12, 31);
    endtask

    task automatic test_odd_fields();
        send_date(2010, 0, 15);
        send_date(2010, 13, 1);
        send_date(2010, 15, 31);
        send_date(2010, 5, 0);
        send_date(2011, 2, 31);
        send_date(2011, 4, 31);
        send_date(1999, 0, 0);
    endtask

    task automatic test_random_dates();
        int y, m, d, month_len;
        for (int blk = 0; blk < 13; blk++) begin
            src_idle = blk[0];
            sink_idle = blk[1];
            for (int n = 0; n < 100; n++) begin
                y = $urandom_range(1900, 2100);
                m = $urandom_range(1, 12);
                month_len = greg_month_days[m - 1];
                if (m == 2 && y % 4 == 0 && (y % 100 != 0 || y % 400 == 0))
                    month_len++;
                d = $urandom_range(1, month_len);
                send_date(y, m, d);
            end
            if (blk % 4 == 3)
                wait_for_drain();
        end
    endtask

    task automatic test_random_fields();
        for (int blk = 0; blk < 6; blk++) begin
            src_idle = $urandom_range(0, 1);
            sink_idle = $urandom_range(0, 1);
            for (int n = 0; n < 50; n++)
                send_date($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_range_edges();
        test_leap_days();
        test_new_year();
        test_odd_fields();
        test_random_dates();
        test_random_fields();
        wait_for_drain();
        repeat (20) @(negedge aclk);
        if (mismatches == 0)
            $display("gregorian_to_jalali_date_tb passed");
        else
            $display("gregorian_to_jalali_date_tb failed");
        $finish;
    end
endmodule
